@@ src/thb_pkg.sv @@
// Shared types and constants for the Thumb ALU with flags.
`default_nettype none
package thb_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OP_W   = 5;

   typedef enum logic [4:0] {
      OP_AND     = 5'd0,
      OP_EOR     = 5'd1,
      OP_LSL     = 5'd2,
      OP_LSR     = 5'd3,
      OP_ASR     = 5'd4,
      OP_ADC     = 5'd5,
      OP_SBC     = 5'd6,
      OP_ROR     = 5'd7,
      OP_TST     = 5'd8,
      OP_NEG     = 5'd9,
      OP_CMP     = 5'd10,
      OP_CMN     = 5'd11,
      OP_ORR     = 5'd12,
      OP_MUL     = 5'd13,
      OP_BIC     = 5'd14,
      OP_MVN     = 5'd15,
      OP_ADD     = 5'd16,
      OP_SUB     = 5'd17,
      OP_MOV     = 5'd18,
      OP_LSL_IMM = 5'd19,
      OP_LSR_IMM = 5'd20,
      OP_ASR_IMM = 5'd21,
      OP_ADD_HI  = 5'd22,
      OP_MOV_HI  = 5'd23,
      OP_COND    = 5'd24
   } op_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_type;

   typedef enum logic [3:0] {
      CC_EQ = 4'd0,
      CC_NE = 4'd1,
      CC_CS = 4'd2,
      CC_CC = 4'd3,
      CC_MI = 4'd4,
      CC_PL = 4'd5,
      CC_VS = 4'd6,
      CC_VC = 4'd7,
      CC_HI = 4'd8,
      CC_LS = 4'd9,
      CC_GE = 4'd10,
      CC_LT = 4'd11,
      CC_GT = 4'd12,
      CC_LE = 4'd13,
      CC_AL = 4'd14,
      CC_NV = 4'd15
   } cond_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              writes_result;
      flags_type         flags;
      logic              cond_true;
   } alu_out_type;

endpackage
`default_nettype wire

@@ src/thumb_alu_with_flags.sv @@
// Top level: input register, single-pass ALU, flag register and result register.
// A transaction accepted at one edge is held in the input register, and its result
// is registered in the result register and shown on rsp_tvalid.
// Throughput: one transaction per cycle unless the result stalls; the NZCV
// register is updated as each operation leaves the input register, so the next
// operation sees it directly. Reset clears both valid bits and the NZCV flags.
`default_nettype none
module thumb_alu_with_flags (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,  // operand_a[31:0], operand_b[63:32]
   input  wire  [4:0]  req_tuser,  // req_type[4:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata   // result[31:0], writes_result[32], flag_n[33],
                                   // flag_z[34], flag_c[35], flag_v[36],
                                   // cond_true[37], zero[39:38]
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [4:0]            in_type_ff;
   logic [31:0]           in_a_ff;
   logic [31:0]           in_b_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   thb_pkg::alu_out_type  out_data_ff;
   thb_pkg::flags_type    flags_ff;
   thb_pkg::flags_type    flags_in;
   thb_pkg::alu_out_type  alu_out;
   logic                  advance;
   logic                  req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   thb_alu u_alu (
      .op_code   (in_type_ff),
      .operand_a (in_a_ff),
      .operand_b (in_b_ff),
      .flags_cur (flags_ff),
      .alu_out   (alu_out)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      flags_in     = advance ? alu_out.flags : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_tuser;
         in_a_ff    <= req_tdata[31:0];
         in_b_ff    <= req_tdata[63:32];
      end
      if (advance) begin
         out_data_ff <= alu_out;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_data_ff.cond_true,
                        out_data_ff.flags.v,
                        out_data_ff.flags.c,
                        out_data_ff.flags.z,
                        out_data_ff.flags.n,
                        out_data_ff.writes_result,
                        out_data_ff.result};

endmodule
`default_nettype wire

@@ src/thb_shifter.sv @@
// Barrel shifter with ARM carry-out rules for LSL, LSR, ASR and ROR.
`default_nettype none
module thb_shifter (
   input  var thb_pkg::shift_type   kind,
   input  wire [thb_pkg::DATA_W-1:0] value,
   input  wire [7:0]                 amount,
   input  wire                       carry_in,
   output logic [thb_pkg::DATA_W-1:0] shifted,
   output logic                      carry_out
);

   logic [32:0] lsl_wide;
   logic [32:0] lsr_wide;
   logic [32:0] asr_wide;
   logic [63:0] ror_wide;
   logic        amt_zero;
   logic        amt_32;
   logic        amt_big;

   assign amt_zero = (amount == 8'd0);
   assign amt_32   = (amount == 8'd32);
   assign amt_big  = (amount > 8'd32);

   assign lsl_wide = {1'b0, value} << amount[4:0];
   assign lsr_wide = {value, 1'b0} >> amount[4:0];
   assign asr_wide = 33'($signed({value, 1'b0}) >>> amount[4:0]);
   assign ror_wide = {value, value} >> amount[4:0];

   always_comb begin
      shifted   = value;
      carry_out = carry_in;
      if (!amt_zero) begin
         case (kind)
            thb_pkg::SH_LSL: begin
               if (amt_32) begin
                  shifted   = '0;
                  carry_out = value[0];
               end else if (amt_big) begin
                  shifted   = '0;
                  carry_out = 1'b0;
               end else begin
                  shifted   = lsl_wide[31:0];
                  carry_out = lsl_wide[32];
               end
            end
            thb_pkg::SH_LSR: begin
               if (amt_32) begin
                  shifted   = '0;
                  carry_out = value[31];
               end else if (amt_big) begin
                  shifted   = '0;
                  carry_out = 1'b0;
               end else begin
                  shifted   = lsr_wide[32:1];
                  carry_out = lsr_wide[0];
               end
            end
            thb_pkg::SH_ASR: begin
               if (amt_32 || amt_big) begin
                  shifted   = {32{value[31]}};
                  carry_out = value[31];
               end else begin
                  shifted   = asr_wide[32:1];
                  carry_out = asr_wide[0];
               end
            end
            default: begin
               shifted   = ror_wide[31:0];
               carry_out = ror_wide[31];
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ src/thb_cond.sv @@
// Condition code evaluation against the current NZCV flags.
`default_nettype none
module thb_cond (
   input  wire [3:0]         code,
   input  var thb_pkg::flags_type flags,
   output logic              holds
);

   logic ge;

   assign ge = (flags.n == flags.v);

   always_comb begin
      unique case (thb_pkg::cond_type'(code))
         thb_pkg::CC_EQ: holds = flags.z;
         thb_pkg::CC_NE: holds = !flags.z;
         thb_pkg::CC_CS: holds = flags.c;
         thb_pkg::CC_CC: holds = !flags.c;
         thb_pkg::CC_MI: holds = flags.n;
         thb_pkg::CC_PL: holds = !flags.n;
         thb_pkg::CC_VS: holds = flags.v;
         thb_pkg::CC_VC: holds = !flags.v;
         thb_pkg::CC_HI: holds = flags.c && !flags.z;
         thb_pkg::CC_LS: holds = !flags.c || flags.z;
         thb_pkg::CC_GE: holds = ge;
         thb_pkg::CC_LT: holds = !ge;
         thb_pkg::CC_GT: holds = !flags.z && ge;
         thb_pkg::CC_LE: holds = flags.z || !ge;
         thb_pkg::CC_AL: holds = 1'b1;
         default:        holds = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

@@ src/thb_alu.sv @@
// Single-pass datapath: adder, multiplier, logic ops, shifter and flag update.
`default_nettype none
module thb_alu (
   input  wire [thb_pkg::OP_W-1:0]   op_code,
   input  wire [thb_pkg::DATA_W-1:0] operand_a,
   input  wire [thb_pkg::DATA_W-1:0] operand_b,
   input  var thb_pkg::flags_type    flags_cur,
   output thb_pkg::alu_out_type      alu_out
);

   thb_pkg::op_type    op;
   thb_pkg::shift_type sh_kind;
   logic [7:0]         sh_amount;
   logic [31:0]        sh_result;
   logic               sh_carry;
   logic [31:0]        add_x;
   logic [31:0]        add_y;
   logic               add_cin;
   logic [32:0]        add_sum;
   logic               add_v;
   logic [31:0]        product;
   logic               cond_holds;
   logic [4:0]         imm;
   logic [31:0]        r;
   logic               set_nz;

   assign op  = thb_pkg::op_type'(op_code);
   assign imm = operand_b[4:0];

   always_comb begin
      add_x   = operand_a;
      add_y   = operand_b;
      add_cin = 1'b0;
      case (op)
         thb_pkg::OP_ADC: add_cin = flags_cur.c;
         thb_pkg::OP_SBC: begin
            add_y   = ~operand_b;
            add_cin = flags_cur.c;
         end
         thb_pkg::OP_NEG: begin
            add_x   = '0;
            add_y   = ~operand_b;
            add_cin = 1'b1;
         end
         thb_pkg::OP_CMP, thb_pkg::OP_SUB: begin
            add_y   = ~operand_b;
            add_cin = 1'b1;
         end
         default: ;
      endcase
   end

   assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
   assign add_v   = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_sum[31]);
   assign product = operand_a * operand_b;

   always_comb begin
      sh_kind   = thb_pkg::SH_LSL;
      sh_amount = operand_b[7:0];
      case (op)
         thb_pkg::OP_LSR: sh_kind = thb_pkg::SH_LSR;
         thb_pkg::OP_ASR: sh_kind = thb_pkg::SH_ASR;
         thb_pkg::OP_ROR: sh_kind = thb_pkg::SH_ROR;
         thb_pkg::OP_LSL_IMM: sh_amount = {3'd0, imm};
         thb_pkg::OP_LSR_IMM: begin
            sh_kind   = thb_pkg::SH_LSR;
            sh_amount = (imm == 5'd0) ? 8'd32 : {3'd0, imm};
         end
         thb_pkg::OP_ASR_IMM: begin
            sh_kind   = thb_pkg::SH_ASR;
            sh_amount = (imm == 5'd0) ? 8'd32 : {3'd0, imm};
         end
         default: ;
      endcase
   end

   thb_shifter u_shifter (
      .kind      (sh_kind),
      .value     (operand_a),
      .amount    (sh_amount),
      .carry_in  (flags_cur.c),
      .shifted   (sh_result),
      .carry_out (sh_carry)
   );

   thb_cond u_cond (
      .code  (operand_a[3:0]),
      .flags (flags_cur),
      .holds (cond_holds)
   );

   always_comb begin
      r                     = '0;
      set_nz                = 1'b0;
      alu_out.writes_result = 1'b1;
      alu_out.cond_true     = 1'b0;
      alu_out.flags         = flags_cur;
      case (op)
         thb_pkg::OP_AND, thb_pkg::OP_TST: begin
            r      = operand_a & operand_b;
            set_nz = 1'b1;
         end
         thb_pkg::OP_EOR: begin
            r      = operand_a ^ operand_b;
            set_nz = 1'b1;
         end
         thb_pkg::OP_ORR: begin
            r      = operand_a | operand_b;
            set_nz = 1'b1;
         end
         thb_pkg::OP_MUL: begin
            r      = product;
            set_nz = 1'b1;
         end
         thb_pkg::OP_BIC: begin
            r      = operand_a & ~operand_b;
            set_nz = 1'b1;
         end
         thb_pkg::OP_MVN: begin
            r      = ~operand_b;
            set_nz = 1'b1;
         end
         thb_pkg::OP_MOV: begin
            r      = operand_b;
            set_nz = 1'b1;
         end
         thb_pkg::OP_LSL, thb_pkg::OP_LSR, thb_pkg::OP_ASR, thb_pkg::OP_ROR,
         thb_pkg::OP_LSL_IMM, thb_pkg::OP_LSR_IMM, thb_pkg::OP_ASR_IMM: begin
            r               = sh_result;
            set_nz          = 1'b1;
            alu_out.flags.c = sh_carry;
         end
         thb_pkg::OP_ADC, thb_pkg::OP_SBC, thb_pkg::OP_NEG, thb_pkg::OP_CMP,
         thb_pkg::OP_CMN, thb_pkg::OP_ADD, thb_pkg::OP_SUB: begin
            r               = add_sum[31:0];
            set_nz          = 1'b1;
            alu_out.flags.c = add_sum[32];
            alu_out.flags.v = add_v;
         end
         thb_pkg::OP_ADD_HI: r = add_sum[31:0];
         thb_pkg::OP_MOV_HI: r = operand_b;
         thb_pkg::OP_COND: begin
            alu_out.writes_result = 1'b0;
            alu_out.cond_true     = cond_holds;
         end
         default: alu_out.writes_result = 1'b0;
      endcase
      if (op == thb_pkg::OP_TST || op == thb_pkg::OP_CMP || op == thb_pkg::OP_CMN) begin
         alu_out.writes_result = 1'b0;
      end
      if (set_nz) begin
         alu_out.flags.n = r[31];
         alu_out.flags.z = (r == 32'd0);
      end
      alu_out.result = r;
   end

endmodule
`default_nettype wire

@@ bench/thumb_alu_checker.sv @@
`timescale 1ns / 100ps
// Checker for thumb_alu_with_flags: keeps its own NZCV, predicts each result and compares it.
module thumb_alu_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [63:0] req_tdata,  // operand_a[31:0], operand_b[63:32]
   input  wire  [4:0]  req_tuser,  // req_type[4:0]
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [39:0] rsp_tdata,  // result[31:0], writes_result[32], flag_n[33], flag_z[34],
                                   // flag_c[35], flag_v[36], cond_true[37], zero[39:38]
   output int          mismatches,
   output int          outstanding
);

   thb_pkg::flags_type   nzcv;
   thb_pkg::alu_out_type pending_results[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Updates C only; N and Z are set by the caller.
   function automatic logic [31:0] shift_value(thb_pkg::shift_type kind, logic [31:0] a,
                                               int amt);
      logic [31:0] r;
      int          k;
      r = a;
      k = amt % 32;
      if (amt != 0) begin
         case (kind)
            thb_pkg::SH_LSL: begin
               if (amt < 32) begin
                  nzcv.c = a[32-amt];
                  r      = a << amt;
               end else begin
                  nzcv.c = (amt == 32) ? a[0] : 1'b0;
                  r      = '0;
               end
            end
            thb_pkg::SH_LSR: begin
               if (amt < 32) begin
                  nzcv.c = a[amt-1];
                  r      = a >> amt;
               end else begin
                  nzcv.c = (amt == 32) ? a[31] : 1'b0;
                  r      = '0;
               end
            end
            thb_pkg::SH_ASR: begin
               if (amt < 32) begin
                  nzcv.c = a[amt-1];
                  r      = $signed(a) >>> amt;
               end else begin
                  nzcv.c = a[31];
                  r      = {32{a[31]}};
               end
            end
            default: begin
               if (k == 0) begin
                  nzcv.c = a[31];
               end else begin
                  nzcv.c = a[k-1];
                  r      = (a >> k) | (a << (32 - k));
               end
            end
         endcase
      end
      return r;
   endfunction

   // Carry and overflow come from the full 33-bit sum.
   function automatic logic [31:0] add_carry(logic [31:0] x, logic [31:0] y, logic cin);
      logic [32:0] s;
      s      = {1'b0, x} + {1'b0, y} + {32'd0, cin};
      nzcv.c = s[32];
      nzcv.v = ~(x[31] ^ y[31]) & (x[31] ^ s[31]);
      return s[31:0];
   endfunction

   function automatic logic cond_holds(logic [3:0] code);
      logic ge;
      ge = (nzcv.n == nzcv.v);
      case (code)
         thb_pkg::CC_EQ: return nzcv.z;
         thb_pkg::CC_NE: return ~nzcv.z;
         thb_pkg::CC_CS: return nzcv.c;
         thb_pkg::CC_CC: return ~nzcv.c;
         thb_pkg::CC_MI: return nzcv.n;
         thb_pkg::CC_PL: return ~nzcv.n;
         thb_pkg::CC_VS: return nzcv.v;
         thb_pkg::CC_VC: return ~nzcv.v;
         thb_pkg::CC_HI: return nzcv.c & ~nzcv.z;
         thb_pkg::CC_LS: return ~nzcv.c | nzcv.z;
         thb_pkg::CC_GE: return ge;
         thb_pkg::CC_LT: return ~ge;
         thb_pkg::CC_GT: return ~nzcv.z & ge;
         thb_pkg::CC_LE: return nzcv.z | ~ge;
         thb_pkg::CC_AL: return 1'b1;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic thb_pkg::alu_out_type thumb_execute(logic [4:0] op, logic [31:0] a,
                                                          logic [31:0] b);
      thb_pkg::alu_out_type o;
      logic [31:0]          r;
      logic                 wr;
      logic                 ct;
      logic                 upd_nz;
      int                   imm_amt;
      r       = '0;
      wr      = 1'b1;
      ct      = 1'b0;
      upd_nz  = 1'b1;
      imm_amt = (b[4:0] == 5'd0) ? 32 : int'(b[4:0]);
      case (op)
         thb_pkg::OP_AND:     r = a & b;
         thb_pkg::OP_EOR:     r = a ^ b;
         thb_pkg::OP_LSL:     r = shift_value(thb_pkg::SH_LSL, a, int'(b[7:0]));
         thb_pkg::OP_LSR:     r = shift_value(thb_pkg::SH_LSR, a, int'(b[7:0]));
         thb_pkg::OP_ASR:     r = shift_value(thb_pkg::SH_ASR, a, int'(b[7:0]));
         thb_pkg::OP_ADC:     r = add_carry(a, b, nzcv.c);
         thb_pkg::OP_SBC:     r = add_carry(a, ~b, nzcv.c);
         thb_pkg::OP_ROR:     r = shift_value(thb_pkg::SH_ROR, a, int'(b[7:0]));
         thb_pkg::OP_TST: begin
            r  = a & b;
            wr = 1'b0;
         end
         thb_pkg::OP_NEG:     r = add_carry('0, ~b, 1'b1);
         thb_pkg::OP_CMP: begin
            r  = add_carry(a, ~b, 1'b1);
            wr = 1'b0;
         end
         thb_pkg::OP_CMN: begin
            r  = add_carry(a, b, 1'b0);
            wr = 1'b0;
         end
         thb_pkg::OP_ORR:     r = a | b;
         thb_pkg::OP_MUL:     r = a * b;
         thb_pkg::OP_BIC:     r = a & ~b;
         thb_pkg::OP_MVN:     r = ~b;
         thb_pkg::OP_ADD:     r = add_carry(a, b, 1'b0);
         thb_pkg::OP_SUB:     r = add_carry(a, ~b, 1'b1);
         thb_pkg::OP_MOV:     r = b;
         thb_pkg::OP_LSL_IMM: r = shift_value(thb_pkg::SH_LSL, a, int'(b[4:0]));
         thb_pkg::OP_LSR_IMM: r = shift_value(thb_pkg::SH_LSR, a, imm_amt);
         thb_pkg::OP_ASR_IMM: r = shift_value(thb_pkg::SH_ASR, a, imm_amt);
         thb_pkg::OP_ADD_HI: begin
            r      = a + b;
            upd_nz = 1'b0;
         end
         thb_pkg::OP_MOV_HI: begin
            r      = b;
            upd_nz = 1'b0;
         end
         thb_pkg::OP_COND: begin
            wr     = 1'b0;
            ct     = cond_holds(a[3:0]);
            upd_nz = 1'b0;
         end
         default: begin
            wr     = 1'b0;
            upd_nz = 1'b0;
         end
      endcase
      if (upd_nz) begin
         nzcv.n = r[31];
         nzcv.z = (r == '0);
      end
      o.result        = r;
      o.writes_result = wr;
      o.flags         = nzcv;
      o.cond_true     = ct;
      return o;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      thb_pkg::alu_out_type want;
      if (reset) begin
         nzcv = '0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("result", want.result, rsp_tdata[31:0]);
               check_field("writes_result", want.writes_result, rsp_tdata[32]);
               check_field("flag_n", want.flags.n, rsp_tdata[33]);
               check_field("flag_z", want.flags.z, rsp_tdata[34]);
               check_field("flag_c", want.flags.c, rsp_tdata[35]);
               check_field("flag_v", want.flags.v, rsp_tdata[36]);
               check_field("cond_true", want.cond_true, rsp_tdata[37]);
               check_field("padding", '0, rsp_tdata[39:38]);
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(
               thumb_execute(req_tuser, req_tdata[31:0], req_tdata[63:32]));
      end
      outstanding = pending_results.size();
   end

endmodule

@@ bench/tb_thumb_alu_with_flags.sv @@
`timescale 1ns / 100ps
// Testbench top for thumb_alu_with_flags: stimulus, handshake stalls, watchdog and verdict.
module tb_thumb_alu_with_flags;

   localparam int          HALF_PERIOD     = 6;
   localparam int          RESET_CYCLES    = 5;
   localparam int          RANDOM_ITEMS    = 1300;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          HOLD_OFF_CYCLES = 64;
   localparam int          DRAIN_CYCLES    = 8;
   localparam logic [4:0]  TYPE_LAST       = 5'd31;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;  // operand_a[31:0], operand_b[63:32]
   logic [4:0]  req_tuser  = '0;  // req_type[4:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // result[31:0], writes_result[32], flag_n[33], flag_z[34],
                                  // flag_c[35], flag_v[36], cond_true[37], zero[39:38]

   int mismatches;
   int outstanding;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;
   bit hold_request = 1'b0;

   thumb_alu_with_flags dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   thumb_alu_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[thumb_alu_with_flags] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_item(logic [4:0] kind, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 32'h0000_0001;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Register shift: low byte is the amount, upper bits are don't-care noise.
   function automatic logic [31:0] pick_shift_operand();
      logic [7:0] amt;
      case ($urandom_range(9))
         0:       amt = 8'd0;
         1:       amt = 8'd1;
         2:       amt = 8'd31;
         3:       amt = 8'd32;
         4:       amt = 8'd33;
         5:       amt = 8'd64;
         6:       amt = 8'd255;
         7:       amt = 8'($urandom_range(40));
         default: amt = 8'($urandom_range(255));
      endcase
      return {24'($urandom()), amt};
   endfunction

   task automatic run_directed();
      send_item(thb_pkg::OP_AND,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(thb_pkg::OP_EOR,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(thb_pkg::OP_LSL,     32'h8000_0001, 32'hFFFF_FF00);
      send_item(thb_pkg::OP_LSL,     32'h0000_0001, 32'd32);
      send_item(thb_pkg::OP_LSR,     32'h8000_0000, 32'hFFFF_FF21);
      send_item(thb_pkg::OP_ASR,     32'h8000_0000, 32'd40);
      send_item(thb_pkg::OP_ROR,     32'h0000_0001, 32'd1);
      send_item(thb_pkg::OP_ROR,     32'h8000_0000, 32'd64);
      send_item(thb_pkg::OP_ADC,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(thb_pkg::OP_SBC,     32'h8000_0000, 32'h0000_0001);
      send_item(thb_pkg::OP_TST,     32'hF0F0_F0F0, 32'h0F0F_0F0F);
      send_item(thb_pkg::OP_NEG,     32'h0000_0000, 32'h8000_0000);
      send_item(thb_pkg::OP_CMP,     32'h0000_0007, 32'h0000_0007);
      send_item(thb_pkg::OP_CMN,     32'hFFFF_FFFF, 32'h0000_0001);
      send_item(thb_pkg::OP_ORR,     32'h0000_0000, 32'h8000_0000);
      send_item(thb_pkg::OP_MUL,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(thb_pkg::OP_BIC,     32'hFFFF_FFFF, 32'h0000_FFFF);
      send_item(thb_pkg::OP_MVN,     32'h0000_0000, 32'h0000_0000);
      send_item(thb_pkg::OP_ADD,     32'h7FFF_FFFF, 32'h0000_0001);
      send_item(thb_pkg::OP_SUB,     32'h0000_0000, 32'h0000_0001);
      send_item(thb_pkg::OP_MOV,     32'hFFFF_FFFF, 32'h0000_0000);
      send_item(thb_pkg::OP_LSL_IMM, 32'h1234_5678, 32'hFFFF_FFE0);
      send_item(thb_pkg::OP_LSR_IMM, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(thb_pkg::OP_ASR_IMM, 32'h8000_0000, 32'h0000_0000);
      send_item(thb_pkg::OP_ADD_HI,  32'hFFFF_FFFF, 32'h0000_0001);
      send_item(thb_pkg::OP_MOV_HI,  32'h0000_0000, 32'hDEAD_BEEF);
      send_item(thb_pkg::OP_COND,    32'(thb_pkg::CC_AL), 32'hFFFF_FFFF);
      send_item(thb_pkg::OP_COND,    32'(thb_pkg::CC_NV), 32'h0000_0000);
      send_item(TYPE_LAST,           32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic run_random(int count);
      logic [4:0]  kind;
      logic [31:0] a;
      logic [31:0] b;
      repeat (count) begin
         if ($urandom_range(19) == 0)
            kind = 5'($urandom_range(TYPE_LAST, thb_pkg::OP_COND + 1));
         else
            kind = 5'($urandom_range(thb_pkg::OP_COND, thb_pkg::OP_AND));
         a = pick_word();
         b = pick_word();
         case (kind)
            thb_pkg::OP_LSL, thb_pkg::OP_LSR, thb_pkg::OP_ASR, thb_pkg::OP_ROR:
               b = pick_shift_operand();
            thb_pkg::OP_LSL_IMM, thb_pkg::OP_LSR_IMM, thb_pkg::OP_ASR_IMM: begin
               if ($urandom_range(3) == 0)
                  b[4:0] = '0;
            end
            thb_pkg::OP_COND: a[3:0] = 4'($urandom_range(thb_pkg::CC_NV, thb_pkg::CC_EQ));
            default: ;
         endcase
         send_item(kind, a, b);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      tx_idle_pct = 13;
      rx_idle_pct = 53;
      run_random(RANDOM_ITEMS / 3);
      tx_idle_pct = 53;
      rx_idle_pct = 13;
      run_random(RANDOM_ITEMS / 3);
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      hold_request = 1'b1;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[thumb_alu_with_flags] OK");
      else
         $display("[thumb_alu_with_flags] ERROR");
      $finish;
   end

endmodule

@@ thumb_alu_with_flags.f @@
src/thb_pkg.sv
src/thb_shifter.sv
src/thb_cond.sv
src/thb_alu.sv
src/thumb_alu_with_flags.sv
bench/thumb_alu_checker.sv
bench/tb_thumb_alu_with_flags.sv
